// ===== rtl/core/ezd_pkg.sv =====
// Package for the Euler angle to direction cosine matrix block.
// Holds widths, CORDIC constants and the arctangent table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ezd_pkg;
   localparam int ANGLE_BITS = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_BITS = COEF_FRAC_BITS + 2;
   localparam int NUM_ITER = 30;
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

   typedef logic signed [CW-1:0] q30_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ezd_cordic.sv =====
// Pipelined rotation-mode CORDIC, one iteration per register stage.
// Uses ezd_pkg; advances when the enable is high.
`timescale 1ns / 1ps
`default_nettype none
module ezd_cordic import ezd_pkg::*; (
   input  wire                  clock,
   input  wire                  enable,
   input  wire [ANGLE_BITS-1:0] angle,
   output q30_type              sin_out,
   output q30_type              cos_out
);
   q30_type x_ff [NUM_ITER+1];
   q30_type y_ff [NUM_ITER+1];
   logic signed [CW-1:0] z_ff [NUM_ITER+1];
   logic neg_ff [NUM_ITER+1];
   logic [31:0] phase;
   logic flip;
   logic [31:0] phase_in;

   always_comb begin
      phase = {angle, {(32-ANGLE_BITS){1'b0}}};
      flip = phase[31] ^ phase[30];
      phase_in = flip ? phase - 32'h80000000 : phase;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= CORDIC_X0;
         y_ff[0] <= '0;
         z_ff[0] <= CW'(signed'(phase_in));
         neg_ff[0] <= flip;
      end
   end

   for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
      localparam logic signed [CW-1:0] ATAN = CW'(atan_entry(5'(i)));
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   assign cos_out = neg_ff[NUM_ITER] ? -x_ff[NUM_ITER] : x_ff[NUM_ITER];
   assign sin_out = neg_ff[NUM_ITER] ? -y_ff[NUM_ITER] : y_ff[NUM_ITER];
endmodule
`default_nettype wire

// ===== rtl/core/ezd_mul.sv =====
// Registered Q30 by Q30 product rounded back to Q30.
// Uses ezd_pkg; advances when the enable is high.
`timescale 1ns / 1ps
`default_nettype none
module ezd_mul import ezd_pkg::*; (
   input  wire     clock,
   input  wire     enable,
   input  q30_type a,
   input  q30_type b,
   output q30_type p
);
   logic signed [2*CW-1:0] prod;
   q30_type p_ff;
   assign prod = a * b + (2*CW)'(64'sd536870912);
   always_ff @(posedge clock) begin
      if (enable) p_ff <= CW'(prod >>> 30);
   end
   assign p = p_ff;
endmodule
`default_nettype wire

// ===== rtl/core/euler_zyx_to_dcm_top.sv =====
// Top level of the Euler angle to direction cosine matrix block.
// Uses ezd_pkg, ezd_cordic and ezd_mul.
`timescale 1ns / 1ps
`default_nettype none
// One set of angles is taken every cycle while the output is not stalled. The pipeline is
// made of the 31 stages of the CORDIC, two multiplier stages and the output register. The
// whole pipeline holds while the output waits.
module euler_zyx_to_dcm_top import ezd_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,  // yaw_angle, pitch_angle, roll_angle
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [143:0] rsp_tdata  // m00, m01, m02, m10, m11, m12, m20, m21, m22
);
   localparam int DEPTH = NUM_ITER + 4;
   localparam int SH = 30 - COEF_FRAC_BITS;
   logic en;
   logic [DEPTH-1:0] vld_ff;
   q30_type sy, cy, sp, cp, sr, cr;
   q30_type srsp, crsp, cy1, sy1, cr1, sr1, sp1;
   q30_type p00, p01, p12, p22, pa, pb, pc, pd, pe, pf, pg, ph;
   q30_type sp2;
   logic [COEF_BITS-1:0] m [9];

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
   end

   ezd_cordic u_yaw (.clock, .enable(en), .angle(req_tdata[15:0]), .sin_out(sy), .cos_out(cy));
   ezd_cordic u_pit (.clock, .enable(en), .angle(req_tdata[31:16]), .sin_out(sp), .cos_out(cp));
   ezd_cordic u_rol (.clock, .enable(en), .angle(req_tdata[47:32]), .sin_out(sr), .cos_out(cr));

   ezd_mul u_srsp (.clock, .enable(en), .a(sr), .b(sp), .p(srsp));
   ezd_mul u_crsp (.clock, .enable(en), .a(cr), .b(sp), .p(crsp));
   ezd_mul u_00 (.clock, .enable(en), .a(cp), .b(cy), .p(p00));
   ezd_mul u_01 (.clock, .enable(en), .a(cp), .b(sy), .p(p01));
   ezd_mul u_12 (.clock, .enable(en), .a(sr), .b(cp), .p(p12));
   ezd_mul u_22 (.clock, .enable(en), .a(cr), .b(cp), .p(p22));

   q30_type p00_ff, p01_ff, p12_ff, p22_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         cy1 <= cy; sy1 <= sy; cr1 <= cr; sr1 <= sr; sp1 <= sp;
         p00_ff <= p00; p01_ff <= p01; p12_ff <= p12; p22_ff <= p22;
         sp2 <= sp1;
      end
   end

   ezd_mul u_a (.clock, .enable(en), .a(srsp), .b(cy1), .p(pa));
   ezd_mul u_b (.clock, .enable(en), .a(cr1), .b(sy1), .p(pb));
   ezd_mul u_c (.clock, .enable(en), .a(cr1), .b(cy1), .p(pc));
   ezd_mul u_d (.clock, .enable(en), .a(srsp), .b(sy1), .p(pd));
   ezd_mul u_e (.clock, .enable(en), .a(crsp), .b(cy1), .p(pe));
   ezd_mul u_f (.clock, .enable(en), .a(sr1), .b(sy1), .p(pf));
   ezd_mul u_g (.clock, .enable(en), .a(crsp), .b(sy1), .p(pg));
   ezd_mul u_h (.clock, .enable(en), .a(sr1), .b(cy1), .p(ph));

   function automatic logic [COEF_BITS-1:0] fin(input q30_type v);
      q30_type r;
      q30_type lim;
      begin
         lim = q30_type'(1) <<< COEF_FRAC_BITS;
         r = (v + (q30_type'(1) <<< (SH-1))) >>> SH;
         if (r > lim) r = lim;
         if (r < -lim) r = -lim;
         return r[COEF_BITS-1:0];
      end
   endfunction

   always_comb begin
      m[0] = fin(p00_ff);
      m[1] = fin(p01_ff);
      m[2] = fin(-sp2);
      m[3] = fin(pa - pb);
      m[4] = fin(pc + pd);
      m[5] = fin(p12_ff);
      m[6] = fin(pe + pf);
      m[7] = fin(pg - ph);
      m[8] = fin(p22_ff);
   end

   // The rounded entries are registered once more to form the output beat.
   always_ff @(posedge clock) begin
      if (en) rsp_tdata <= {m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
   end
endmodule
`default_nettype wire
